// ===== rtl/lpfr_pkg.sv =====
package lpfr_pkg;

    // Payload offset at which message text starts
    localparam int unsigned TEXT_OFFSET = 6;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHAN_MSG_TYPE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAITING_TYPE  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH    = 2'd3;

    // Register reset values
    localparam logic [7:0]  START_BYTE_RST    = 8'd62;
    localparam logic [7:0]  CHAN_MSG_TYPE_RST = 8'd8;
    localparam logic [7:0]  WAITING_TYPE_RST  = 8'd131;
    localparam logic [15:0] MAX_LENGTH_RST    = 16'd511;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_LEN_LO = 2'd1,
        PH_LEN_HI = 2'd2,
        PH_DATA   = 2'd3
    } rx_phase_t;

    typedef enum logic [1:0] {
        KIND_OTHER   = 2'd0,
        KIND_CHAN    = 2'd1,
        KIND_FETCH   = 2'd2,
        KIND_DROPPED = 2'd3
    } frame_kind_t;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  chan_msg_type;
        logic [7:0]  waiting_type;
        logic [15:0] max_length;
    } cfg_t;

    typedef struct packed {
        logic        text_valid;
        logic [7:0]  text_byte;
        logic        frame_end;
        frame_kind_t frame_kind;
        logic [7:0]  channel;
    } result_t;

endpackage

// ===== rtl/lpfr_cfg_regs.sv =====
module lpfr_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lpfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lpfr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output lpfr_pkg::cfg_t                    cfg
);
    import lpfr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_START_BYTE:    cfg_next.start_byte    = cfg_wdata[7:0];
                CFG_CHAN_MSG_TYPE: cfg_next.chan_msg_type = cfg_wdata[7:0];
                CFG_WAITING_TYPE:  cfg_next.waiting_type  = cfg_wdata[7:0];
                CFG_MAX_LENGTH:    cfg_next.max_length    = cfg_wdata[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_byte    <= START_BYTE_RST;
            cfg_reg.chan_msg_type <= CHAN_MSG_TYPE_RST;
            cfg_reg.waiting_type  <= WAITING_TYPE_RST;
            cfg_reg.max_length    <= MAX_LENGTH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/lpfr_core.sv =====
module lpfr_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    input  lpfr_pkg::cfg_t      cfg,
    output lpfr_pkg::result_t   result
);
    import lpfr_pkg::*;

    rx_phase_t   phase_reg,   phase_next;
    logic [15:0] length_reg,  length_next;
    logic [15:0] count_reg,   count_next;
    logic [7:0]  type_reg,    type_next;
    logic [7:0]  chan_reg,    chan_next;
    logic        ended_reg,   ended_next;

    logic [15:0] len_full;
    logic [16:0] count_inc;
    logic        is_chan;

    // next state
    always_comb begin
        phase_next  = phase_reg;
        length_next = length_reg;
        count_next  = count_reg;
        type_next   = type_reg;
        chan_next   = chan_reg;
        ended_next  = ended_reg;
        len_full    = {rx_byte, length_reg[7:0]};
        count_inc   = {1'b0, count_reg} + 17'd1;
        case (phase_reg)
            PH_START: begin
                if (rx_byte == cfg.start_byte) begin
                    phase_next = PH_LEN_LO;
                    count_next = '0;
                    type_next  = '0;
                    chan_next  = '0;
                    ended_next = 1'b0;
                end
            end
            PH_LEN_LO: begin
                length_next = {8'h00, rx_byte};
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                length_next = len_full;
                phase_next  = (len_full > cfg.max_length) ? PH_START : PH_DATA;
            end
            PH_DATA: begin
                if (count_reg == 16'd0) type_next = rx_byte;
                if (count_reg == 16'd1) chan_next = rx_byte;
                if ((type_next == cfg.chan_msg_type) &&
                    (count_reg >= 16'(TEXT_OFFSET)) && !ended_reg &&
                    (rx_byte == 8'h00)) begin
                    ended_next = 1'b1;
                end
                count_next = count_inc[15:0];
                if (count_inc >= {1'b0, length_reg}) phase_next = PH_START;
            end
            default: phase_next = PH_START;
        endcase
    end

    assign is_chan = (type_next == cfg.chan_msg_type);

    // result for this item
    always_comb begin
        result            = '0;
        result.frame_kind = KIND_OTHER;
        result.channel    = chan_next;
        case (phase_reg)
            PH_LEN_HI: begin
                if (len_full > cfg.max_length) begin
                    result.frame_end  = 1'b1;
                    result.frame_kind = KIND_DROPPED;
                end
            end
            PH_DATA: begin
                if (is_chan && (count_reg >= 16'(TEXT_OFFSET)) && !ended_reg &&
                    (rx_byte != 8'h00)) begin
                    result.text_valid = 1'b1;
                    result.text_byte  = rx_byte;
                end
                if (count_inc >= {1'b0, length_reg}) begin
                    result.frame_end = 1'b1;
                    if (length_reg == 16'd0)
                        result.frame_kind = KIND_OTHER;
                    else if (is_chan && (length_reg >= 16'(TEXT_OFFSET)))
                        result.frame_kind = KIND_CHAN;
                    else if (type_next == cfg.waiting_type)
                        result.frame_kind = KIND_FETCH;
                    else
                        result.frame_kind = KIND_OTHER;
                end
            end
            default: result.frame_kind = KIND_OTHER;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_START;
            length_reg <= '0;
            count_reg  <= '0;
            type_reg   <= '0;
            chan_reg   <= '0;
            ended_reg  <= 1'b0;
        end else if (step) begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            type_reg   <= type_next;
            chan_reg   <= chan_next;
            ended_reg  <= ended_next;
        end
    end

endmodule

// ===== rtl/length_prefixed_frame_receiver.sv =====
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata[7:0] = rx_byte
// m_        out  m_tvalid/m_tready  m_tdata = text_byte, channel; m_tlast = frame_end;
//                                   m_tuser = text_valid, frame_kind
// cfg_      in   cfg_wr_en          cfg_index, cfg_wdata (write only)
//
// One result item for every received byte, one item per cycle sustained while m_tready stays high.
// Path: input register, then frame logic into the output register.
// Reset (aresetn, synchronous, active low) puts the deframer back to hunting
// for the start byte and loads the register defaults.
// A stall on m_ holds the output register and, once it is full, the input register; s_tready
// then drops until the pipeline can move again.
module length_prefixed_frame_receiver (
    input  logic                              aclk,
    input  logic                              aresetn,
    // received bytes
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // [7:0] text_byte, [15:8] channel
    output logic                              m_tlast,   // frame_end
    output logic [2:0]                        m_tuser,   // [0] text_valid, [2:1] frame_kind
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [lpfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lpfr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import lpfr_pkg::*;

    cfg_t    cfg;
    result_t core_result;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // output register
    logic       out_valid_reg;
    result_t    out_reg;

    logic advance;   // output stage free this cycle
    logic step;      // item in the input register is processed

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    lpfr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lpfr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.channel, out_reg.text_byte};
    assign m_tlast  = out_reg.frame_end;
    assign m_tuser  = {out_reg.frame_kind, out_reg.text_valid};

endmodule

// ===== test/length_prefixed_frame_receiver_test.sv =====
`timescale 1ns / 1ps

module length_prefixed_frame_receiver_test;
    import lpfr_pkg::*;

    localparam int unsigned N_PHASES     = 6;
    localparam int unsigned PHASE_ITEMS  = 188;     // random items per register setting
    localparam int unsigned DRAIN_CYCLES = 8;       // two-stage pipeline, plus margin
    localparam int unsigned HOLDOFF      = 300;     // long m_ stall right after reset
    localparam int unsigned CYCLE_LIMIT  = 100000;

    // One row of the directed table. typed_in rows carry a hand-written
    // expectation; the rest take the predictor's.
    typedef struct {
        logic [7:0] rx_byte;
        bit         typed_in;
        result_t    want;
    } stim_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;     // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;               // [7:0] text_byte, [15:8] channel
    logic        m_tlast;               // frame_end
    logic [2:0]  m_tuser;               // [0] text_valid, [2:1] frame_kind
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // Deframer state as the testbench sees it
    cfg_t       cfg;
    rx_phase_t  ph;
    logic [15:0] flen;
    logic [15:0] nbytes;
    logic [7:0]  ftype;
    logic [7:0]  fchan;
    logic        text_done;

    result_t   results_due[$];
    int        n_bytes_sent  = 0;
    int        n_mismatches  = 0;
    int        n_cycles      = 0;
    int        tx_idle_pct   = 14;
    int        rx_idle_pct   = 48;
    int        holdoff_left  = HOLDOFF;

    length_prefixed_frame_receiver i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("length_prefixed_frame_receiver_test: done, errors");
            $finish;
        end
    end

    // Predicts the result item for one received byte and advances the state.
    function automatic result_t deframe_byte(input logic [7:0] b);
        result_t     r;
        logic [16:0] cnt;
        r = '0;
        case (ph)
            PH_START: begin
                if (b == cfg.start_byte) begin
                    ph        = PH_LEN_LO;
                    nbytes    = '0;
                    ftype     = '0;
                    fchan     = '0;
                    text_done = 1'b0;
                end
            end
            PH_LEN_LO: begin
                flen = {8'h00, b};
                ph   = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                flen[15:8] = b;
                if (flen > cfg.max_length) begin
                    // oversize: reported at once, no payload taken
                    ph           = PH_START;
                    r.frame_end  = 1'b1;
                    r.frame_kind = KIND_DROPPED;
                end else begin
                    ph = PH_DATA;
                end
            end
            PH_DATA: begin
                if (nbytes == 0) ftype = b;
                if (nbytes == 1) fchan = b;
                // text runs from the offset up to the first zero, never past the frame
                if (ftype == cfg.chan_msg_type && nbytes >= TEXT_OFFSET && !text_done) begin
                    if (b == 8'h00) begin
                        text_done = 1'b1;
                    end else begin
                        r.text_valid = 1'b1;
                        r.text_byte  = b;
                    end
                end
                cnt    = {1'b0, nbytes} + 17'd1;
                nbytes = cnt[15:0];
                // a zero-length frame still ends on its first payload byte
                if (cnt >= {1'b0, flen}) begin
                    r.frame_end = 1'b1;
                    if (flen == 0)
                        r.frame_kind = KIND_OTHER;
                    else if (ftype == cfg.chan_msg_type && flen >= TEXT_OFFSET)
                        r.frame_kind = KIND_CHAN;
                    else if (ftype == cfg.waiting_type)
                        r.frame_kind = KIND_FETCH;
                    else
                        r.frame_kind = KIND_OTHER;
                    ph = PH_START;
                end
            end
        endcase
        r.channel = fchan;
        return r;
    endfunction

    function automatic stim_row_t fixed_row(input logic [7:0] b, input logic fe,
                                            input frame_kind_t kind, input logic [7:0] ch);
        stim_row_t row;
        row.rx_byte         = b;
        row.typed_in        = 1'b1;
        row.want            = '0;
        row.want.frame_end  = fe;
        row.want.frame_kind = kind;
        row.want.channel    = ch;
        return row;
    endfunction

    function automatic stim_row_t open_row(input logic [7:0] b);
        stim_row_t row;
        row.rx_byte  = b;
        row.typed_in = 1'b0;
        row.want     = '0;
        return row;
    endfunction

    // Offers one item, idling at random first; s_tvalid is left high so
    // back-to-back items need no second assignment in the same step.
    task automatic send_byte(input stim_row_t row);
        result_t predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row.rx_byte;
        do @(posedge aclk); while (!s_tready);
        predicted = deframe_byte(row.rx_byte);
        results_due.push_back(row.typed_in ? row.want : predicted);
        n_bytes_sent++;
    endtask

    // Stop offering and let every expected item come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes all four registers back to back; only while the block is idle.
    task automatic set_config(input cfg_t c);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_START_BYTE;
        cfg_wdata <= {8'h00, c.start_byte};
        @(posedge aclk);
        cfg_index <= CFG_CHAN_MSG_TYPE;
        cfg_wdata <= {8'h00, c.chan_msg_type};
        @(posedge aclk);
        cfg_index <= CFG_WAITING_TYPE;
        cfg_wdata <= {8'h00, c.waiting_type};
        @(posedge aclk);
        cfg_index <= CFG_MAX_LENGTH;
        cfg_wdata <= c.max_length;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg = c;
    endtask

    // One random sequence: mostly well-formed frames with random content,
    // the rest noise, oversize headers and frames cut short.
    task automatic send_frame();
        int          pick;
        int          top;
        int          n_pay;
        logic [15:0] lenv;
        logic [7:0]  b;
        pick = $urandom_range(99);
        if (pick < 10 || (pick < 20 && cfg.max_length == 16'hFFFF)) begin
            repeat ($urandom_range(3, 1)) send_byte(open_row(8'($urandom_range(255))));
        end else if (pick < 20) begin
            if ($urandom_range(1))
                lenv = cfg.max_length + 16'd1;
            else
                lenv = 16'($urandom_range(65535, int'(cfg.max_length) + 1));
            send_byte(open_row(cfg.start_byte));
            send_byte(open_row(lenv[7:0]));
            send_byte(open_row(lenv[15:8]));
        end else begin
            top  = (cfg.max_length < 24) ? int'(cfg.max_length) : 24;
            lenv = 16'($urandom_range(top, 0));
            // now and then the full allowed length, or a length from 256 to 300
            if ($urandom_range(19) == 0)
                lenv = (cfg.max_length < 300) ? cfg.max_length : 16'($urandom_range(300, 256));
            send_byte(open_row(cfg.start_byte));
            send_byte(open_row(lenv[7:0]));
            send_byte(open_row(lenv[15:8]));
            n_pay = (lenv == 0) ? 1 : int'(lenv);
            // cut short: the next frame's bytes land in this one's payload
            if (n_pay > 1 && $urandom_range(15) == 0) n_pay = $urandom_range(n_pay - 1, 1);
            for (int i = 0; i < n_pay; i++) begin
                if (i == 0) begin
                    case ($urandom_range(3))
                        0, 1:    b = cfg.chan_msg_type;
                        2:       b = cfg.waiting_type;
                        default: b = 8'($urandom_range(255));
                    endcase
                end else if (i < TEXT_OFFSET) begin
                    b = 8'($urandom_range(255));
                end else begin
                    b = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(255, 1));
                end
                send_byte(open_row(b));
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_mismatches++;
        end
    endtask

    // Result side: random stalls, one long hold-off after reset while the
    // directed items back up into the block, then compare each item.
    always @(posedge aclk) begin : collect
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                $error("result item with none expected: tdata %h tlast %b tuser %b",
                       m_tdata, m_tlast, m_tuser);
                n_mismatches++;
            end else begin
                want = results_due.pop_front();
                check_field("text_valid", 8'(want.text_valid), 8'(m_tuser[0]));
                check_field("text_byte",  want.text_byte,       m_tdata[7:0]);
                check_field("frame_end",  8'(want.frame_end),   8'(m_tlast));
                check_field("frame_kind", 8'(want.frame_kind),  8'(m_tuser[2:1]));
                check_field("channel",    want.channel,         m_tdata[15:8]);
            end
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (holdoff_left != 0) begin
            m_tready     <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        stim_row_t directed [28];
        cfg_t      c;

        // Reset values of the registers and the deframer
        cfg.start_byte    = START_BYTE_RST;
        cfg.chan_msg_type = CHAN_MSG_TYPE_RST;
        cfg.waiting_type  = WAITING_TYPE_RST;
        cfg.max_length    = MAX_LENGTH_RST;
        ph        = PH_START;
        flen      = '0;
        nbytes    = '0;
        ftype     = '0;
        fchan     = '0;
        text_done = 1'b0;

        directed = '{
            // stray byte while hunting: ignored
            fixed_row(8'hFF, 1'b0, KIND_OTHER, 8'h00),
            // length 0xFFFF: dropped as soon as the high byte lands
            fixed_row(START_BYTE_RST, 1'b0, KIND_OTHER, 8'h00),
            fixed_row(8'hFF, 1'b0, KIND_OTHER, 8'h00),
            fixed_row(8'hFF, 1'b1, KIND_DROPPED, 8'h00),
            // zero-length frame still eats one byte
            fixed_row(START_BYTE_RST, 1'b0, KIND_OTHER, 8'h00),
            fixed_row(8'h00, 1'b0, KIND_OTHER, 8'h00),
            fixed_row(8'h00, 1'b0, KIND_OTHER, 8'h00),
            fixed_row(8'hAA, 1'b1, KIND_OTHER, 8'h00),
            // channel message, length 8: text runs to the frame end, no zero
            open_row(START_BYTE_RST), open_row(8'd8), open_row(8'h00),
            open_row(CHAN_MSG_TYPE_RST), open_row(8'h05),
            open_row(8'h80), open_row(8'h7F), open_row(8'h01), open_row(8'hFE),
            open_row(8'h48), open_row(8'hFF),
            // messages-waiting, length 2: fetch request
            open_row(START_BYTE_RST), open_row(8'd2), open_row(8'h00),
            open_row(WAITING_TYPE_RST), open_row(8'h07),
            // channel type but shorter than the text offset: plain frame
            open_row(START_BYTE_RST), open_row(8'd1), open_row(8'h00),
            open_row(CHAN_MSG_TYPE_RST)
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) send_byte(directed[i]);

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            case (p)
                // lowest limits; both type codes equal
                0: c = '{start_byte: 8'h00, chan_msg_type: 8'hFF,
                         waiting_type: 8'hFF, max_length: 16'h0000};
                1: c = '{start_byte: 8'hFF, chan_msg_type: 8'h00,
                         waiting_type: 8'h00, max_length: 16'hFFFF};
                2: c = '{start_byte: START_BYTE_RST, chan_msg_type: CHAN_MSG_TYPE_RST,
                         waiting_type: WAITING_TYPE_RST, max_length: MAX_LENGTH_RST};
                default: begin
                    c.start_byte    = 8'($urandom_range(255));
                    c.chan_msg_type = 8'($urandom_range(255));
                    c.waiting_type  = ($urandom_range(3) == 0) ? c.chan_msg_type
                                                               : 8'($urandom_range(255));
                    c.max_length    = $urandom_range(1) ? 16'($urandom_range(40))
                                                        : 16'($urandom_range(600));
                end
            endcase
            set_config(c);
            // idle mix: sender light / receiver heavy, then swapped, then none
            case (p / 2)
                0:       begin tx_idle_pct = 14; rx_idle_pct = 48; end
                1:       begin tx_idle_pct = 48; rx_idle_pct = 14; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            while (n_bytes_sent < $size(directed) + (p + 1) * PHASE_ITEMS) send_frame();
        end

        drain();
        if (n_mismatches == 0)
            $display("length_prefixed_frame_receiver_test: done, clean");
        else
            $display("length_prefixed_frame_receiver_test: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lpfr_pkg.sv
rtl/lpfr_cfg_regs.sv
rtl/lpfr_core.sv
rtl/length_prefixed_frame_receiver.sv
test/length_prefixed_frame_receiver_test.sv
